FILE: hw/rtl/lei_pkg.sv
// ----------------------------------------------------------------------------
// lei_pkg
// Shared micro-op codes, register map and controller/datapath interface types
// for the Lorenz Euler integrator.
// ----------------------------------------------------------------------------
package lei_pkg;

	// register map
	localparam int CFG_W     = 28;
	localparam int CFG_IDX_W = 3;
	localparam int SIGMA_W   = 27;
	localparam int RHO_W     = 28;
	localparam int BETA_W    = 25;
	localparam int DT_W      = 17;
	localparam int IDX_W     = 20;

	localparam logic [CFG_IDX_W-1:0] REG_SIGMA       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RHO         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BETA        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd4;

	localparam logic [SIGMA_W-1:0] SIGMA_RST = 27'd10485760;
	localparam logic [RHO_W-1:0]   RHO_RST   = 28'd29360128;
	localparam logic [BETA_W-1:0]  BETA_RST  = 25'd2796203;
	localparam logic [DT_W-1:0]    DT_RST    = 17'd1049;
	localparam logic [IDX_W-1:0]   COUNT_RST = 20'd200000;

	// micro-ops, multiply ops are consecutive so the sequencer can count through them
	typedef logic [3:0] op_t;
	localparam op_t OP_NONE    = 4'd0;
	localparam op_t OP_RESTART = 4'd1;
	localparam op_t OP_DIFF    = 4'd2;
	localparam op_t OP_MUL_DX  = 4'd3;
	localparam op_t OP_MUL_XB  = 4'd4;
	localparam op_t OP_MUL_XY  = 4'd5;
	localparam op_t OP_MUL_BZ  = 4'd6;
	localparam op_t OP_MUL_TX  = 4'd7;
	localparam op_t OP_MUL_TY  = 4'd8;
	localparam op_t OP_MUL_TZ  = 4'd9;

	typedef struct packed {
		logic clear_flags;
		logic op_valid;
		op_t  op;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic out_free;
	} status_t;

endpackage

FILE: hw/rtl/lei_mul.sv
// ----------------------------------------------------------------------------
// lei_mul
// Iterative fixed-point multiplier: four half-width partial products, then
// shift with floor rounding and saturation to the value word.
// ----------------------------------------------------------------------------
module lei_mul #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 20,
	localparam int MAG_W      = (VALUE_WIDTH > 28) ? VALUE_WIDTH : 28
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [MAG_W:0]         opnd_a,
	input  logic signed [MAG_W:0]         opnd_b,
	output logic                          done,
	output logic signed [VALUE_WIDTH-1:0] prod,
	output logic                          prod_sat
);

	localparam int H  = MAG_W / 2 + 1;
	localparam int AW = 4 * H;
	localparam int QW = AW - FRAC_BITS;
	localparam logic [QW:0] LIM = (QW + 1)'(1) << (VALUE_WIDTH - 1);

	logic          busy_q, fin_q, done_q, neg_q, sat_q;
	logic [1:0]    k_q;
	logic [2*H-1:0] ma_q, mb_q;
	logic [AW-1:0] acc_q;
	logic signed [VALUE_WIDTH-1:0] prod_q;

	logic [MAG_W:0]  abs_a, abs_b;
	logic [H-1:0]    half_a, half_b;
	logic [2*H-1:0]  pp;
	logic [AW-1:0]   pp_sh;
	logic [QW:0]     q, qn;
	logic            rem_nz;
	logic signed [VALUE_WIDTH-1:0] res;
	logic            res_sat;

	always_comb begin
		abs_a  = opnd_a[MAG_W] ? (~opnd_a + 1'b1) : opnd_a;
		abs_b  = opnd_b[MAG_W] ? (~opnd_b + 1'b1) : opnd_b;
		half_a = k_q[0] ? ma_q[2*H-1:H] : ma_q[H-1:0];
		half_b = k_q[1] ? mb_q[2*H-1:H] : mb_q[H-1:0];
		pp     = half_a * half_b;
		case (k_q)
			2'd0:    pp_sh = AW'(pp);
			2'd3:    pp_sh = AW'(pp) << (2 * H);
			default: pp_sh = AW'(pp) << H;
		endcase
	end

	// floor of the signed product, saturated
	always_comb begin
		q       = {1'b0, acc_q[AW-1:FRAC_BITS]};
		rem_nz  = (acc_q[FRAC_BITS-1:0] != '0);
		qn      = q + (QW + 1)'(rem_nz);
		res     = '0;
		res_sat = 1'b0;
		if (neg_q) begin
			if (qn > LIM) begin
				res     = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
				res_sat = 1'b1;
			end else begin
				res = VALUE_WIDTH'(0) - qn[VALUE_WIDTH-1:0];
			end
		end else begin
			if (q > LIM - 1'b1) begin
				res     = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
				res_sat = 1'b1;
			end else begin
				res = q[VALUE_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= busy_q && (k_q == 2'd3);
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				k_q <= k_q + 1'b1;
				if (k_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= opnd_a[MAG_W] ^ opnd_b[MAG_W];
			ma_q  <= {{(2*H-MAG_W){1'b0}}, abs_a[MAG_W-1:0]};
			mb_q  <= {{(2*H-MAG_W){1'b0}}, abs_b[MAG_W-1:0]};
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
		if (fin_q) begin
			prod_q <= res;
			sat_q  <= res_sat;
		end
	end

	assign done     = done_q;
	assign prod     = prod_q;
	assign prod_sat = sat_q;

	a_no_start_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (!busy_q && !fin_q))
		else $error("multiplier started while a product is in flight");

endmodule

FILE: hw/rtl/lei_datapath.sv
// ----------------------------------------------------------------------------
// lei_datapath
// Point state, configuration registers, saturating adders, shared multiplier
// and output register of the Lorenz Euler integrator.
// ----------------------------------------------------------------------------
module lei_datapath #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lei_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lei_pkg::CFG_W-1:0]     cfg_data,
	input  lei_pkg::cmd_t                 cmd,
	output lei_pkg::status_t              status,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            x_pos,
	output logic signed [31:0]            y_pos,
	output logic signed [31:0]            z_pos,
	output logic                          last_point,
	output logic                          overflow
);
	import lei_pkg::*;

	localparam int VW    = VALUE_WIDTH;
	localparam int MAG_W = (VW > 28) ? VW : 28;
	localparam int OPW   = MAG_W + 1;
	localparam int EW    = MAG_W + 2;
	localparam logic signed [EW-1:0] MAX_E = $signed({{(EW-VW+1){1'b0}}, {(VW-1){1'b1}}});
	localparam logic signed [EW-1:0] MIN_E = -MAX_E - 1;
	localparam logic signed [EW-1:0] ONE_E = EW'(1) << FRAC_BITS;

	function automatic logic signed [EW-1:0] ext(input logic signed [VW-1:0] v);
		ext = {{(EW-VW){v[VW-1]}}, v};
	endfunction

	function automatic logic signed [OPW-1:0] opx(input logic signed [VW-1:0] v);
		opx = {{(OPW-VW){v[VW-1]}}, v};
	endfunction

	// {flag, value}
	function automatic logic [VW:0] sat_w(input logic signed [EW-1:0] v);
		if (v > MAX_E) begin
			sat_w = {1'b1, MAX_E[VW-1:0]};
		end else if (v < MIN_E) begin
			sat_w = {1'b1, MIN_E[VW-1:0]};
		end else begin
			sat_w = {1'b0, v[VW-1:0]};
		end
	endfunction

	logic [SIGMA_W-1:0] sigma_q;
	logic [RHO_W-1:0]   rho_q;
	logic [BETA_W-1:0]  beta_q;
	logic [DT_W-1:0]    dt_q;
	logic [IDX_W-1:0]   count_q, idx_q;

	logic signed [VW-1:0] x_q, y_q, z_q, ta_q, tb_q, dx_q, dy_q, dz_q;
	logic ovf_q;

	logic out_valid_q, last_q, ovf_out_q;
	logic signed [31:0] xo_q, yo_q, zo_q;

	logic                 mul_start, mul_done, mul_sat;
	logic signed [OPW-1:0] opnd_a, opnd_b;
	logic signed [VW-1:0] prod;

	logic [VW:0] s_one, s_yx, s_rz, s_wb;
	logic signed [EW-1:0] wb_a, wb_b;
	logic [IDX_W-1:0] cnt_m1;
	logic out_free;

	lei_mul #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.opnd_a  (opnd_a),
		.opnd_b  (opnd_b),
		.done    (mul_done),
		.prod    (prod),
		.prod_sat(mul_sat)
	);

	// operand select for the shared multiplier
	always_comb begin
		mul_start = 1'b0;
		opnd_a    = '0;
		opnd_b    = '0;
		case (cmd.op)
			OP_MUL_DX: begin
				opnd_a = {{(OPW-SIGMA_W){1'b0}}, sigma_q};
				opnd_b = opx(ta_q);
			end
			OP_MUL_XB: begin
				opnd_a = opx(x_q);
				opnd_b = opx(tb_q);
			end
			OP_MUL_XY: begin
				opnd_a = opx(x_q);
				opnd_b = opx(y_q);
			end
			OP_MUL_BZ: begin
				opnd_a = {{(OPW-BETA_W){1'b0}}, beta_q};
				opnd_b = opx(z_q);
			end
			OP_MUL_TX: begin
				opnd_a = {{(OPW-DT_W){1'b0}}, dt_q};
				opnd_b = opx(dx_q);
			end
			OP_MUL_TY: begin
				opnd_a = {{(OPW-DT_W){1'b0}}, dt_q};
				opnd_b = opx(dy_q);
			end
			OP_MUL_TZ: begin
				opnd_a = {{(OPW-DT_W){1'b0}}, dt_q};
				opnd_b = opx(dz_q);
			end
			default: begin
				opnd_a = '0;
				opnd_b = '0;
			end
		endcase
		if (cmd.op_valid && (cmd.op >= OP_MUL_DX) && (cmd.op <= OP_MUL_TZ)) begin
			mul_start = 1'b1;
		end
	end

	// one shared writeback adder
	always_comb begin
		s_one = sat_w(ONE_E);
		s_yx  = sat_w(ext(y_q) - ext(x_q));
		s_rz  = sat_w($signed({{(EW-RHO_W){1'b0}}, rho_q}) - ext(z_q));
		wb_a  = ext(prod);
		wb_b  = '0;
		case (cmd.op)
			OP_MUL_XB: begin
				wb_a = ext(prod);
				wb_b = -ext(y_q);
			end
			OP_MUL_BZ: begin
				wb_a = ext(dz_q);
				wb_b = -ext(prod);
			end
			OP_MUL_TX: wb_b = ext(x_q);
			OP_MUL_TY: wb_b = ext(y_q);
			OP_MUL_TZ: wb_b = ext(z_q);
			default:   wb_b = '0;
		endcase
		s_wb = sat_w(wb_a + wb_b);
	end

	assign cnt_m1   = (count_q == '0) ? '0 : count_q - 1'b1;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= SIGMA_RST;
			rho_q   <= RHO_RST;
			beta_q  <= BETA_RST;
			dt_q    <= DT_RST;
			count_q <= COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIGMA:       sigma_q <= cfg_data[SIGMA_W-1:0];
				REG_RHO:         rho_q   <= cfg_data[RHO_W-1:0];
				REG_BETA:        beta_q  <= cfg_data[BETA_W-1:0];
				REG_TIME_STEP:   dt_q    <= cfg_data[DT_W-1:0];
				REG_POINT_COUNT: count_q <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= s_one[VW-1:0];
			y_q   <= s_one[VW-1:0];
			z_q   <= s_one[VW-1:0];
			ta_q  <= '0;
			tb_q  <= '0;
			dx_q  <= '0;
			dy_q  <= '0;
			dz_q  <= '0;
			idx_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.clear_flags) begin
				ovf_q <= 1'b0;
			end
			if (cmd.op_valid && (cmd.op == OP_RESTART)) begin
				x_q   <= s_one[VW-1:0];
				y_q   <= s_one[VW-1:0];
				z_q   <= s_one[VW-1:0];
				idx_q <= '0;
				ovf_q <= s_one[VW];
			end
			if (cmd.op_valid && (cmd.op == OP_DIFF)) begin
				ta_q  <= s_yx[VW-1:0];
				tb_q  <= s_rz[VW-1:0];
				ovf_q <= ovf_q | s_yx[VW] | s_rz[VW];
			end
			if (mul_done) begin
				case (cmd.op)
					OP_MUL_DX: begin
						dx_q  <= prod;
						ovf_q <= ovf_q | mul_sat;
					end
					OP_MUL_XY: begin
						dz_q  <= prod;
						ovf_q <= ovf_q | mul_sat;
					end
					OP_MUL_XB: begin
						dy_q  <= s_wb[VW-1:0];
						ovf_q <= ovf_q | mul_sat | s_wb[VW];
					end
					OP_MUL_BZ: begin
						dz_q  <= s_wb[VW-1:0];
						ovf_q <= ovf_q | mul_sat | s_wb[VW];
					end
					OP_MUL_TX: begin
						x_q   <= s_wb[VW-1:0];
						ovf_q <= ovf_q | mul_sat | s_wb[VW];
					end
					OP_MUL_TY: begin
						y_q   <= s_wb[VW-1:0];
						ovf_q <= ovf_q | mul_sat | s_wb[VW];
					end
					OP_MUL_TZ: begin
						z_q   <= s_wb[VW-1:0];
						ovf_q <= ovf_q | mul_sat | s_wb[VW];
						if (idx_q < cnt_m1) begin
							idx_q <= idx_q + 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			xo_q      <= 32'(64'(x_q));
			yo_q      <= 32'(64'(y_q));
			zo_q      <= 32'(64'(z_q));
			last_q    <= (idx_q >= cnt_m1);
			ovf_out_q <= ovf_q;
		end
	end

	assign status.mul_done = mul_done;
	assign status.out_free = out_free;
	assign out_valid  = out_valid_q;
	assign x_pos      = xo_q;
	assign y_pos      = yo_q;
	assign z_pos      = zo_q;
	assign last_point = last_q;
	assign overflow   = ovf_out_q;

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> out_free)
		else $error("output register overwritten before it was taken");

	a_restart_clears_index: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op_valid && cmd.op == OP_RESTART) |=> (idx_q == '0))
		else $error("restart did not clear the point index");

endmodule

FILE: hw/rtl/lei_ctrl.sv
// ----------------------------------------------------------------------------
// lei_ctrl
// Sequencer for the Lorenz Euler integrator: accepts a transaction, walks the
// micro-op list through the datapath and hands the point to the output.
// ----------------------------------------------------------------------------
module lei_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              restart,
	input  lei_pkg::status_t  status,
	output lei_pkg::cmd_t     cmd
);
	import lei_pkg::*;

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_RESTART   = 3'd1;
	localparam logic [2:0] S_DIFF      = 3'd2;
	localparam logic [2:0] S_MUL_ISSUE = 3'd3;
	localparam logic [2:0] S_MUL_WAIT  = 3'd4;
	localparam logic [2:0] S_DONE      = 3'd5;

	logic [2:0] state_q;
	op_t        op_q;

	always_comb begin
		in_ready        = 1'b0;
		cmd.clear_flags = 1'b0;
		cmd.op_valid    = 1'b0;
		cmd.op          = OP_NONE;
		cmd.load_out    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready        = 1'b1;
				cmd.clear_flags = in_valid;
			end
			S_RESTART: begin
				cmd.op_valid = 1'b1;
				cmd.op       = OP_RESTART;
			end
			S_DIFF: begin
				cmd.op_valid = 1'b1;
				cmd.op       = OP_DIFF;
			end
			S_MUL_ISSUE: begin
				cmd.op_valid = 1'b1;
				cmd.op       = op_q;
			end
			S_MUL_WAIT: cmd.op = op_q;
			S_DONE:     cmd.load_out = status.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_NONE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= restart ? S_RESTART : S_DIFF;
					end
				end
				S_RESTART: state_q <= S_DONE;
				S_DIFF: begin
					op_q    <= OP_MUL_DX;
					state_q <= S_MUL_ISSUE;
				end
				S_MUL_ISSUE: state_q <= S_MUL_WAIT;
				S_MUL_WAIT: begin
					if (status.mul_done) begin
						if (op_q == OP_MUL_TZ) begin
							state_q <= S_DONE;
						end else begin
							op_q    <= op_q + 1'b1;
							state_q <= S_MUL_ISSUE;
						end
					end
				end
				S_DONE: begin
					if (status.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transaction accepted while one is in work");

	a_last_product_ends_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL_WAIT && status.mul_done && op_q == OP_MUL_TZ) |=> (state_q == S_DONE))
		else $error("step did not finish after the last product");

endmodule

FILE: hw/rtl/lorenz_euler_integrator.sv
// ----------------------------------------------------------------------------
// lorenz_euler_integrator
// Lorenz attractor point generator, one forward Euler step or restart per
// transaction, signed fixed point with saturation on every sum and product.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  input    in_valid / in_ready     restart
//  output   out_valid / out_ready   x_pos, y_pos, z_pos, last_point, overflow
//  config   cfg_we                  cfg_index, cfg_data
//
//  a step runs from accept to result as the difference terms, then seven
//  products one after another through the single four-pass multiplier, then
//  the load of the output register
//  a restart goes from accept straight to the load of the output register
//  one transaction is in work at a time; the next is taken the cycle after the
//  result has entered the output register, while that result still waits for
//  out_ready; a full output register holds the finished point back
//  reset puts the point at (1,1,1), the index at 0 and the registers at defaults
// ----------------------------------------------------------------------------
module lorenz_euler_integrator #(
	parameter int FRAC_BITS   = 20,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input transaction
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          restart,
	// result transaction
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            x_pos,
	output logic signed [31:0]            y_pos,
	output logic signed [31:0]            z_pos,
	output logic                          last_point,
	output logic                          overflow,
	// register writes
	input  logic                          cfg_we,
	input  logic [lei_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lei_pkg::CFG_W-1:0]     cfg_data
);
	import lei_pkg::*;

	// controller to datapath commands and status back
	cmd_t    cmd;
	status_t status;

	// sequencer: accept, restart or difference terms and seven products, hand-off
	lei_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.restart (restart),
		.status  (status),
		.cmd     (cmd)
	);

	// point state, registers, adders, multiplier, output register
	lei_datapath #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.z_pos     (z_pos),
		.last_point(last_point),
		.overflow  (overflow)
	);

endmodule
